FILE: design/htfd_pkg.sv
package htfd_pkg;

	localparam int unsigned FRAME_BYTES = 6;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [1:0] REG_HUM_OFFSET  = 2'd0;
	localparam logic [1:0] REG_TEMP_OFFSET = 2'd1;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 18;
	localparam int unsigned HUM_OFF_W   = 18;
	localparam int unsigned TEMP_OFF_W  = 17;
	localparam int unsigned RAW_W       = 20;
	localparam int unsigned VALUE_W     = 19;
	localparam int unsigned SUM_W       = 20;

	localparam logic [2:0] POS_CHECKSUM = 3'd6;

	localparam logic signed [SUM_W-1:0] VALUE_MIN = -20'sd102400;
	localparam logic signed [SUM_W-1:0] VALUE_MAX = 20'sd204799;
	localparam logic signed [SUM_W-1:0] TEMP_BIAS = 20'sd51200;

	typedef struct packed {
		logic [7:0]       status;
		logic [RAW_W-1:0] hum_raw;
		logic [RAW_W-1:0] temp_raw;
		logic             crc_ok;
	} frame_t;

	function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/htfd_if.sv
interface htfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_out_if;
	logic               valid;
	logic               ready;
	logic        [7:0]  status_byte;
	logic        [19:0] humidity_raw;
	logic        [19:0] temperature_raw;
	logic signed [18:0] humidity_value;
	logic signed [18:0] temperature_value;
	logic               checksum_ok;

	modport source (output valid, output status_byte, output humidity_raw,
		output temperature_raw, output humidity_value, output temperature_value,
		output checksum_ok, input ready);
	modport sink (input valid, input status_byte, input humidity_raw,
		input temperature_raw, input humidity_value, input temperature_value,
		input checksum_ok, output ready);
endinterface

FILE: design/humidity_temp_frame_decoder.sv
// Decodes the seven-byte measurement frame of a humidity and temperature sensor, taking one
// byte per transaction on in_ch and producing one result transaction on out_ch after the
// checksum byte, with the raw fields, the scaled values in 1/1024 units plus the configured
// offsets (saturated to their range), and the CRC-8 check result. A byte with frame_start
// high restarts the frame. The block accepts one byte every clock cycle unless the frame
// register holds an untaken result. A result passes through the frame register and then the
// output register after the conversion logic. The user must write offsets through cfg_we,
// cfg_index and cfg_data only while no frame is in flight; the block does not enforce it.
module humidity_temp_frame_decoder
	import htfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	htfd_in_if.sink                in_ch,
	htfd_out_if.source             out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic   valid_s1;
	logic   take_s1;
	frame_t frame_s1;

	htfd_assembler u_assembler (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.data_byte   (in_ch.data_byte),
		.frame_start (in_ch.frame_start),
		.take_s1     (take_s1),
		.valid_s1    (valid_s1),
		.frame_s1    (frame_s1)
	);

	htfd_convert u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.frame_s1  (frame_s1),
		.take_s1   (take_s1),
		.out_ch    (out_ch)
	);

endmodule

FILE: design/htfd_assembler.sv
module htfd_assembler
	import htfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic       take_s1,
	output logic       valid_s1,
	output frame_t     frame_s1
);

	logic [2:0] pos_q;
	logic [7:0] crc_q;
	logic [7:0] store_q [FRAME_BYTES];

	logic       accept;
	logic [2:0] pos_eff;
	logic [7:0] crc_eff;
	logic       last_byte;

	assign in_ready  = !valid_s1 || take_s1;
	assign accept    = in_valid && in_ready;
	assign pos_eff   = frame_start ? 3'd0 : pos_q;
	assign crc_eff   = frame_start ? CRC_INIT : crc_q;
	assign last_byte = (pos_eff == POS_CHECKSUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			valid_s1 <= 1'b0;
		end else begin
			if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (last_byte) begin
					pos_q    <= '0;
					crc_q    <= CRC_INIT;
					valid_s1 <= 1'b1;
				end else begin
					pos_q <= pos_eff + 3'd1;
					crc_q <= crc8_feed(crc_eff, data_byte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_byte) begin
			store_q[pos_eff] <= data_byte;
		end
		if (accept && last_byte) begin
			frame_s1.status   <= store_q[0];
			frame_s1.hum_raw  <= {store_q[1], store_q[2], store_q[3][7:4]};
			frame_s1.temp_raw <= {store_q[3][3:0], store_q[4], store_q[5]};
			frame_s1.crc_ok   <= (crc_eff == data_byte);
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_CHECKSUM)
		else $error("byte position out of range");

	a_start_pos: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_start |=> pos_q == 3'd1)
		else $error("frame start did not restart assembly");

	a_emit_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> valid_s1 && pos_q == 3'd0 && crc_q == CRC_INIT)
		else $error("checksum byte did not close the frame");

endmodule

FILE: design/htfd_convert.sv
module htfd_convert
	import htfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   valid_s1,
	input  frame_t                 frame_s1,
	output logic                   take_s1,
	htfd_out_if.source             out_ch
);

	logic signed [HUM_OFF_W-1:0]  hum_off_q;
	logic signed [TEMP_OFF_W-1:0] temp_off_q;

	logic [26:0]             hum_prod;
	logic [27:0]             temp_prod;
	logic signed [SUM_W-1:0] hum_sum;
	logic signed [SUM_W-1:0] temp_sum;
	logic signed [SUM_W-1:0] hum_sat;
	logic signed [SUM_W-1:0] temp_sat;

	assign take_s1 = valid_s1 && (!out_ch.valid || out_ch.ready);

	assign hum_prod  = {7'd0, frame_s1.hum_raw} * 27'd100;
	assign temp_prod = {8'd0, frame_s1.temp_raw} * 28'd200;

	assign hum_sum  = $signed({3'd0, hum_prod[26:10]})
		+ $signed({{(SUM_W-HUM_OFF_W){hum_off_q[HUM_OFF_W-1]}}, hum_off_q});
	assign temp_sum = $signed({2'd0, temp_prod[27:10]}) - TEMP_BIAS
		+ $signed({{(SUM_W-TEMP_OFF_W){temp_off_q[TEMP_OFF_W-1]}}, temp_off_q});

	always_comb begin
		if (hum_sum < VALUE_MIN) begin
			hum_sat = VALUE_MIN;
		end else if (hum_sum > VALUE_MAX) begin
			hum_sat = VALUE_MAX;
		end else begin
			hum_sat = hum_sum;
		end
		if (temp_sum < VALUE_MIN) begin
			temp_sat = VALUE_MIN;
		end else if (temp_sum > VALUE_MAX) begin
			temp_sat = VALUE_MAX;
		end else begin
			temp_sat = temp_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_off_q  <= '0;
			temp_off_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HUM_OFFSET:  hum_off_q  <= cfg_data[HUM_OFF_W-1:0];
				REG_TEMP_OFFSET: temp_off_q <= cfg_data[TEMP_OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (take_s1) begin
			out_ch.valid <= 1'b1;
		end else if (out_ch.ready) begin
			out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			out_ch.status_byte       <= frame_s1.status;
			out_ch.humidity_raw      <= frame_s1.hum_raw;
			out_ch.temperature_raw   <= frame_s1.temp_raw;
			out_ch.humidity_value    <= hum_sat[VALUE_W-1:0];
			out_ch.temperature_value <= temp_sat[VALUE_W-1:0];
			out_ch.checksum_ok       <= frame_s1.crc_ok;
		end
	end

	a_take_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !take_s1)
		else $error("result overwritten before it was taken");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> out_ch.valid)
		else $error("decoded frame lost on the way to the output");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |-> hum_sat >= VALUE_MIN && hum_sat <= VALUE_MAX
			&& temp_sat >= VALUE_MIN && temp_sat <= VALUE_MAX)
		else $error("converted value outside its range");

endmodule

FILE: test/testbench.sv
module testbench;
	import htfd_pkg::*;

	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          PHASES         = 9;
	localparam int          PHASE_BYTES    = 150;
	localparam int          HOLD_CYCLES    = 300;
	localparam logic [1:0]  REG_SPARE_A    = 2'd2;
	localparam logic [1:0]  REG_SPARE_B    = 2'd3;

	typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

	typedef struct {
		logic [7:0]         status;
		logic [RAW_W-1:0]   hum_raw;
		logic [RAW_W-1:0]   temp_raw;
		logic signed [18:0] hum_val;
		logic signed [18:0] temp_val;
		logic               crc_ok;
	} frame_result_t;

	class frame_scoreboard;
		logic signed [HUM_OFF_W-1:0]  hum_off;
		logic signed [TEMP_OFF_W-1:0] temp_off;
		logic [2:0]                   pos;
		logic [7:0]                   crc;
		logic [7:0]                   store [FRAME_BYTES];
		frame_result_t                result_q[$];
		int                           mismatches;
		int                           frames_checked;

		function new();
			hum_off = '0;
			temp_off = '0;
			pos = '0;
			crc = CRC_INIT;
			mismatches = 0;
			frames_checked = 0;
		endfunction

		// Bit-serial form of the CRC-8 update, most significant bit first.
		static function logic [7:0] crc_byte(logic [7:0] c, logic [7:0] b);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ b[i];
				c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		static function longint saturate(longint v);
			if (v < longint'(VALUE_MIN)) return longint'(VALUE_MIN);
			if (v > longint'(VALUE_MAX)) return longint'(VALUE_MAX);
			return v;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_HUM_OFFSET: hum_off = data[HUM_OFF_W-1:0];
				REG_TEMP_OFFSET: temp_off = data[TEMP_OFF_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		function void note_byte(logic [7:0] b, logic start);
			frame_result_t r;
			longint        h;
			longint        t;
			if (start) begin
				pos = '0;
				crc = CRC_INIT;
			end
			if (pos < POS_CHECKSUM) begin
				store[pos] = b;
				crc = crc_byte(crc, b);
				pos++;
			end else begin
				r.status = store[0];
				r.hum_raw = {store[1], store[2], store[3][7:4]};
				r.temp_raw = {store[3][3:0], store[4], store[5]};
				h = longint'(r.hum_raw) * 100 / 1024 + longint'(hum_off);
				t = longint'(r.temp_raw) * 200 / 1024 - longint'(TEMP_BIAS)
					+ longint'(temp_off);
				h = saturate(h);
				t = saturate(t);
				r.hum_val = h[18:0];
				r.temp_val = t[18:0];
				r.crc_ok = (crc == b);
				result_q.push_back(r);
				pos = '0;
				crc = CRC_INIT;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(frame_result_t got);
			frame_result_t exp;
			if (result_q.size() == 0) begin
				report("result transaction with no frame pending");
				return;
			end
			exp = result_q.pop_front();
			frames_checked++;
			if (got.status !== exp.status)
				report($sformatf("status_byte got %0h expected %0h", got.status, exp.status));
			if (got.hum_raw !== exp.hum_raw)
				report($sformatf("humidity_raw got %0h expected %0h",
					got.hum_raw, exp.hum_raw));
			if (got.temp_raw !== exp.temp_raw)
				report($sformatf("temperature_raw got %0h expected %0h",
					got.temp_raw, exp.temp_raw));
			if (got.hum_val !== exp.hum_val)
				report($sformatf("humidity_value got %0d expected %0d",
					got.hum_val, exp.hum_val));
			if (got.temp_val !== exp.temp_val)
				report($sformatf("temperature_value got %0d expected %0d",
					got.temp_val, exp.temp_val));
			if (got.crc_ok !== exp.crc_ok)
				report($sformatf("checksum_ok got %0b expected %0b", got.crc_ok, exp.crc_ok));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	htfd_in_if  in_ch();
	htfd_out_if out_ch();

	humidity_temp_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	frame_scoreboard sb = new();

	int cycle_count   = 0;
	int bytes_sent    = 0;
	int settings_used = 1;
	int burst_left    = 0;
	bit steady_sender = 0;
	int hold_request  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task send_byte(logic [7:0] b, logic start);
		if (!steady_sender && burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.frame_start <= start;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_byte(b, start);
		bytes_sent++;
	endtask

	task send_frame(logic use_start, bit good_crc, fill_t fill);
		logic [7:0] bytes [7];
		logic [7:0] c;
		c = CRC_INIT;
		for (int i = 0; i < 6; i++) begin
			case (fill)
				FILL_ZERO: bytes[i] = 8'h00;
				FILL_ONES: bytes[i] = 8'hFF;
				default: bytes[i] = 8'($urandom);
			endcase
			if (i == 0 && fill != FILL_RANDOM && $urandom_range(0, 1))
				bytes[i] = 8'($urandom);
			c = frame_scoreboard::crc_byte(c, bytes[i]);
		end
		bytes[6] = good_crc ? c : c ^ 8'($urandom_range(1, 255));
		for (int i = 0; i < 7; i++)
			send_byte(bytes[i], (i == 0) ? use_start : 1'b0);
	endtask

	// Completes any partial frame and waits for the block to go quiet.
	task settle();
		while (sb.pos != 0)
			send_byte(8'($urandom), 1'b0);
		in_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task program_offsets(logic [CFG_DATA_W-1:0] hum, logic [CFG_DATA_W-1:0] temp);
		logic [CFG_INDEX_W-1:0] spare;
		logic [CFG_DATA_W-1:0]  junk;
		spare = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
		junk = CFG_DATA_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_HUM_OFFSET;
		cfg_data <= hum;
		@(posedge clk);
		sb.write_reg(REG_HUM_OFFSET, hum);
		cfg_index <= REG_TEMP_OFFSET;
		cfg_data <= temp;
		@(posedge clk);
		sb.write_reg(REG_TEMP_OFFSET, temp);
		cfg_index <= spare;
		cfg_data <= junk;
		@(posedge clk);
		sb.write_reg(spare, junk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task random_traffic(int count);
		int target;
		int r;
		int n;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_frame((sb.pos != 0) ? 1'b1 : 1'($urandom_range(0, 1)),
					$urandom_range(0, 7) != 0,
					fill_t'(($urandom_range(0, 7) < 2) ? $urandom_range(0, 1) : FILL_RANDOM));
			end else if (r < 88) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_byte(8'($urandom), i == 0);
			end else begin
				send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Receiver: a randomly redrawn ready pattern, with long hold-offs on request.
	initial begin
		logic [15:0]   pattern;
		int            hold_left;
		frame_result_t got;
		out_ch.ready = 1'b0;
		pattern = 16'hFFFF;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (cycle_count % 64 == 0)
				pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= pattern[cycle_count % 16];
			end
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.status = out_ch.status_byte;
				got.hum_raw = out_ch.humidity_raw;
				got.temp_raw = out_ch.temperature_raw;
				got.hum_val = out_ch.humidity_value;
				got.temp_val = out_ch.temperature_value;
				got.crc_ok = out_ch.checksum_ok;
				sb.check_result(got);
			end
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] hum;
		logic [CFG_DATA_W-1:0] temp;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_HUM_OFFSET;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.frame_start = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme frames, a frame taken by wrap-around, a restart mid-frame, a bad checksum.
		send_frame(1'b1, 1'b1, FILL_ZERO);
		send_frame(1'b0, 1'b1, FILL_ONES);
		for (int i = 0; i < 3; i++)
			send_byte(8'($urandom), i == 0);
		send_frame(1'b1, 1'b0, FILL_RANDOM);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: begin hum = 18'sd102400; temp = 18'sd51200; end
					2: begin hum = -18'sd102400; temp = -18'sd51200; end
					3: begin hum = 18'sd131071; temp = 18'sd65535; end
					4: begin hum = -18'sd131072; temp = 18'h10000; end
					default: begin
						hum = CFG_DATA_W'($urandom);
						temp = CFG_DATA_W'($urandom);
					end
				endcase
				program_offsets(hum, temp);
			end
			steady_sender = ($urandom_range(0, 3) == 0);
			if (p == 3 || p == 6) begin
				steady_sender = 1'b1;
				hold_request = HOLD_CYCLES;
			end
			random_traffic(PHASE_BYTES);
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d expected results never arrived", sb.pending()));
		$display("Sent %0d bytes and checked %0d decoded frames over %0d offset settings,",
			bytes_sent, sb.frames_checked, settings_used);
		$display("including restarts, wrap-around frames, bad checksums and saturated values.");
		if (sb.mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

FILE: sim.f
design/htfd_pkg.sv
design/htfd_if.sv
design/htfd_assembler.sv
design/htfd_convert.sv
design/humidity_temp_frame_decoder.sv
test/testbench.sv
